// File: rtl/dte_pkg.sv
// ----------------------------------------------------------------------------
// dte_pkg
// Types and constants of the DMA transfer engine: opcodes, register offsets,
// transfer modes, memory spaces and fixed memory sizes.
// ----------------------------------------------------------------------------
package dte_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_REG_READ  = 2'd0,
        OP_REG_WRITE = 2'd1,
        OP_BEAT      = 2'd2,
        OP_NOP       = 2'd3
    } t_opcode;

    // Register offsets within the DMA page
    localparam logic [3:0] REG_SRC_LO    = 4'd0;
    localparam logic [3:0] REG_SRC_HI    = 4'd1;
    localparam logic [3:0] REG_DST_LO    = 4'd2;
    localparam logic [3:0] REG_DST_HI    = 4'd3;
    localparam logic [3:0] REG_CONTROL   = 4'd4;
    localparam logic [3:0] REG_RUN_COUNT = 4'd5;
    localparam logic [3:0] REG_FILL      = 4'd6;
    localparam logic [3:0] REG_DATA_PORT = 4'd7;
    localparam logic [3:0] REG_TABLE     = 4'd8;
    localparam logic [3:0] REG_ROW_JUMP  = 4'd9;

    // Configuration register indexes
    localparam logic CFG_MAP_WIDTH = 1'b0;
    localparam logic CFG_FOUR_BPP  = 1'b1;

    // Transfer modes, control bits 2-0
    typedef enum logic [2:0] {
        MODE_COPY    = 3'd0,
        MODE_FILL    = 3'd1,
        MODE_MASKED  = 3'd2,
        MODE_ALT     = 3'd3,
        MODE_PIXEL   = 3'd4,
        MODE_PALETTE = 3'd5,
        MODE_SPRITE  = 3'd6,
        MODE_SPR_CLR = 3'd7
    } t_mode;

    // Memory spaces
    typedef enum logic [1:0] {
        SP_CPU     = 2'd0,
        SP_VRAM    = 2'd1,
        SP_PALETTE = 2'd2,
        SP_SPRITE  = 2'd3
    } t_space;

    // Control byte bits
    localparam int CTL_TO_VRAM   = 7;
    localparam int CTL_FROM_VRAM = 6;
    localparam int CTL_VERTICAL  = 5;
    localparam int CTL_REVERSE   = 4;

    // Memory sizes
    localparam int PALETTE_ENTRIES = 64;
    localparam int SPRITE_BYTES    = 160;

    // Data constants
    localparam logic [7:0]  UNUSED_BYTE  = 8'hEE;
    localparam logic [7:0]  CLEAR_BYTE   = 8'hFF;
    localparam logic [15:0] ROW_JUMP     = 16'd640;
    localparam logic [15:0] ROW_UNIT     = 16'd64;
    localparam logic [15:0] CLR_FWD_STEP = 16'd4;
    localparam logic [15:0] CLR_REV_STEP = 16'hFFFC;
    localparam logic [15:0] STEP_FWD     = 16'd1;
    localparam logic [15:0] STEP_REV     = 16'hFFFF;
    localparam logic [15:0] SPR_ROW_MASK = 16'h00FC;
    localparam logic [8:0]  RUN_FULL     = 9'd256;

    // Reset values of the engine registers
    localparam logic [15:0] SRC_RESET   = 16'h1111;
    localparam logic [15:0] DST_RESET   = 16'h2222;
    localparam logic [7:0]  CTRL_RESET  = 8'h33;
    localparam logic [7:0]  DATA_RESET  = 8'h77;
    localparam logic [7:0]  TABLE_RESET = 8'h55;
    localparam logic [1:0]  MAPW_RESET  = 2'd1;

endpackage

// File: rtl/dma_transfer_engine.sv
// ----------------------------------------------------------------------------
// dma_transfer_engine
// Byte-register DMA engine: register reads and writes and transfer beats,
// at most one write request per beat in one of eight transfer modes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | into      | i_in_valid / o_in_stall   | opcode, reg_index,
//          |           |                           | bus_byte, fetched_byte
//  out     | out of    | o_out_valid / i_out_stall | read_byte, write request,
//          |           |                           | next source, beats_left
//  cfg     | into      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  One item per clock, sustained while the output does not stall. An item is
//  captured in the input register, executed against the engine registers,
//  and its result lands in the output register.
//  The input register and the output register give two slots, so an item
//  is taken while a finished result still waits downstream.
//  Reset is synchronous and active low; no clearing pass.
//  A stall on the output holds the result; the input stalls only once both
//  slots are full.
//
module dma_transfer_engine
    import dte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_reg_index,
    input  logic [7:0]  i_bus_byte,
    input  logic [7:0]  i_fetched_byte,

    // Result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_byte,
    output logic        o_write_enable,
    output logic [1:0]  o_write_space,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic [1:0]  o_source_space,
    output logic [15:0] o_source_address,
    output logic [8:0]  o_beats_left,

    // Configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] r_map_width;
    logic       r_four_bpp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= MAPW_RESET;
            r_four_bpp  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH: r_map_width <= i_cfg_data;
                CFG_FOUR_BPP:  r_four_bpp  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       r_in_valid;
    t_opcode    r_in_opcode;
    logic [3:0] r_in_reg;
    logic [7:0] r_in_bus;
    logic [7:0] r_in_fetched;

    logic in_take;   // transfer on the input channel
    logic exec;      // item in the input register executes this cycle

    assign exec       = r_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_opcode  <= t_opcode'(i_opcode);
            r_in_reg     <= i_reg_index;
            r_in_bus     <= i_bus_byte;
            r_in_fetched <= i_fetched_byte;
        end
    end

    // ------------------------------------------------------------------
    // Engine registers
    // ------------------------------------------------------------------
    logic [15:0] r_src,   n_src;
    logic [15:0] r_dst,   n_dst;
    logic [7:0]  r_ctrl,  n_ctrl;
    logic [7:0]  r_data,  n_data;
    logic [7:0]  r_table, n_table;
    logic [8:0]  r_run,   n_run;

    // ------------------------------------------------------------------
    // Execute: one item against the engine registers
    // ------------------------------------------------------------------
    t_mode       mode;
    t_mode       next_mode;
    logic [15:0] src_step;
    logic [15:0] row_step;
    logic [15:0] dst_step;
    logic [7:0]  fetch_val;   // source byte after the sprite range check
    logic [7:0]  read_val;    // byte a source read cycle yields
    logic        do_read;
    logic        do_write;
    logic        plain_vram;
    logic [15:0] plain_addr;
    logic [7:0]  pix_mask;
    logic        spr_in_range;

    logic [7:0]  n_read_byte;
    logic        n_wr_en;
    t_space      n_wr_space;
    logic [15:0] n_wr_addr;
    logic [7:0]  n_wr_data;
    t_space      n_src_space;
    logic [15:0] n_src_addr;

    always_comb begin
        mode     = t_mode'(r_ctrl[2:0]);
        src_step = r_ctrl[CTL_REVERSE] ? STEP_REV : STEP_FWD;
        row_step = 16'(ROW_UNIT << r_map_width);

        // Destination step; sprite-clear widens the unit step to a whole entry
        if (r_ctrl[CTL_REVERSE]) begin
            dst_step = r_ctrl[CTL_VERTICAL] ? (16'd0 - row_step) : STEP_REV;
        end else begin
            dst_step = r_ctrl[CTL_VERTICAL] ? row_step : STEP_FWD;
        end
        if (mode == MODE_SPR_CLR && !r_ctrl[CTL_VERTICAL]) begin
            dst_step = r_ctrl[CTL_REVERSE] ? CLR_REV_STEP : CLR_FWD_STEP;
        end

        fetch_val = ((mode == MODE_SPRITE || mode == MODE_SPR_CLR) &&
                     (r_src >= 16'(SPRITE_BYTES))) ? UNUSED_BYTE : r_in_fetched;
        // fill mode never fetches: the latch stands
        read_val  = (mode == MODE_FILL) ? r_data : fetch_val;

        n_src       = r_src;
        n_dst       = r_dst;
        n_ctrl      = r_ctrl;
        n_data      = r_data;
        n_table     = r_table;
        n_run       = r_run;
        n_read_byte = 8'h00;
        do_read     = 1'b0;
        do_write    = 1'b0;

        case (r_in_opcode)
            OP_REG_READ: begin
                case (r_in_reg)
                    REG_SRC_LO:    n_read_byte = r_src[7:0];
                    REG_SRC_HI:    n_read_byte = r_src[15:8];
                    REG_DST_LO:    n_read_byte = r_dst[7:0];
                    REG_DST_HI:    n_read_byte = r_dst[15:8];
                    REG_CONTROL:   n_read_byte = r_ctrl;
                    REG_FILL:      n_read_byte = r_data;
                    REG_DATA_PORT: begin
                        n_read_byte = read_val;
                        do_read     = 1'b1;
                    end
                    default:       n_read_byte = UNUSED_BYTE;
                endcase
            end
            OP_REG_WRITE: begin
                case (r_in_reg)
                    REG_SRC_LO:    n_src   = {r_src[15:8], r_in_bus};
                    REG_SRC_HI:    n_src   = {r_in_bus, r_src[7:0]};
                    REG_DST_LO:    n_dst   = {r_dst[15:8], r_in_bus};
                    REG_DST_HI:    n_dst   = {r_in_bus, r_dst[7:0]};
                    REG_CONTROL:   n_ctrl  = r_in_bus;
                    REG_RUN_COUNT: n_run   = (r_in_bus == 8'h00) ? RUN_FULL
                                                                 : {1'b0, r_in_bus};
                    REG_FILL:      n_data  = r_in_bus;
                    REG_DATA_PORT: begin
                        do_write = 1'b1;
                        // pixel mode: byte is the new pixels, old byte comes in
                        if (mode == MODE_PIXEL) begin
                            n_table = r_in_bus;
                            do_read = 1'b1;
                        end else begin
                            n_data  = r_in_bus;
                        end
                    end
                    REG_TABLE:     n_table = r_in_bus;
                    REG_ROW_JUMP:  n_dst   = r_dst + ROW_JUMP;
                    default: ;
                endcase
            end
            OP_BEAT: begin
                do_read  = 1'b1;
                do_write = 1'b1;
                n_run    = (r_run != 9'd0) ? (r_run - 9'd1) : 9'd0;
            end
            default: ;
        endcase

        if (do_read && mode != MODE_FILL) begin
            n_data = fetch_val;
            n_src  = r_src + src_step;
        end

        // Write request, from the latches as left by the read cycle
        plain_vram   = r_ctrl[CTL_TO_VRAM];
        plain_addr   = plain_vram ? {2'b00, r_dst[13:0]} : r_dst;
        spr_in_range = (r_dst < 16'(SPRITE_BYTES));
        if (r_four_bpp) begin
            pix_mask = r_dst[2] ? 8'h1E : 8'h0F;
        end else begin
            pix_mask = 8'(8'd3 << r_dst[2:1]);
        end

        n_wr_en    = 1'b0;
        n_wr_space = SP_CPU;
        n_wr_addr  = 16'h0000;
        n_wr_data  = 8'h00;
        if (do_write) begin
            n_dst = r_dst + dst_step;
            case (mode)
                MODE_COPY, MODE_FILL: begin
                    n_wr_en    = 1'b1;
                    n_wr_space = plain_vram ? SP_VRAM : SP_CPU;
                    n_wr_addr  = plain_addr;
                    n_wr_data  = n_data;
                end
                MODE_MASKED: begin
                    // zero bytes are transparent
                    if (n_data != 8'h00) begin
                        n_wr_en    = 1'b1;
                        n_wr_space = plain_vram ? SP_VRAM : SP_CPU;
                        n_wr_addr  = plain_addr;
                        n_wr_data  = n_data;
                    end
                end
                MODE_ALT: begin
                    n_wr_en    = 1'b1;
                    n_wr_space = plain_vram ? SP_VRAM : SP_CPU;
                    n_wr_addr  = plain_addr;
                    n_wr_data  = r_dst[0] ? n_table : n_data;
                end
                MODE_PIXEL: begin
                    n_wr_en    = 1'b1;
                    n_wr_space = plain_vram ? SP_VRAM : SP_CPU;
                    n_wr_addr  = plain_vram ? {3'b000, r_dst[15:3]} : r_dst;
                    n_wr_data  = (n_data & ~pix_mask) | (n_table & pix_mask);
                end
                MODE_PALETTE: begin
                    n_wr_en    = 1'b1;
                    n_wr_space = SP_PALETTE;
                    n_wr_addr  = 16'(r_dst % PALETTE_ENTRIES);
                    n_wr_data  = n_data;
                end
                MODE_SPRITE: begin
                    if (spr_in_range) begin
                        n_wr_en    = 1'b1;
                        n_wr_space = SP_SPRITE;
                        n_wr_addr  = r_dst;
                        n_wr_data  = n_data;
                    end
                end
                default: begin
                    // sprite-clear: whole entry, aligned to four bytes
                    if (spr_in_range) begin
                        n_wr_en    = 1'b1;
                        n_wr_space = SP_SPRITE;
                        n_wr_addr  = r_dst & SPR_ROW_MASK;
                        n_wr_data  = CLEAR_BYTE;
                    end
                end
            endcase
        end

        // Next source location, under the control byte as this item leaves it
        next_mode = t_mode'(n_ctrl[2:0]);
        case (next_mode)
            MODE_PIXEL: begin
                n_src_space = n_ctrl[CTL_FROM_VRAM] ? SP_VRAM : SP_CPU;
                n_src_addr  = n_ctrl[CTL_FROM_VRAM] ? {3'b000, n_src[15:3]} : n_src;
            end
            MODE_PALETTE: begin
                n_src_space = SP_PALETTE;
                n_src_addr  = 16'(n_src % PALETTE_ENTRIES);
            end
            MODE_SPRITE, MODE_SPR_CLR: begin
                n_src_space = SP_SPRITE;
                n_src_addr  = n_src;
            end
            default: begin
                n_src_space = n_ctrl[CTL_FROM_VRAM] ? SP_VRAM : SP_CPU;
                n_src_addr  = n_ctrl[CTL_FROM_VRAM] ? {2'b00, n_src[13:0]} : n_src;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src   <= SRC_RESET;
            r_dst   <= DST_RESET;
            r_ctrl  <= CTRL_RESET;
            r_data  <= DATA_RESET;
            r_table <= TABLE_RESET;
            r_run   <= 9'd0;
        end else if (exec) begin
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_ctrl  <= n_ctrl;
            r_data  <= n_data;
            r_table <= n_table;
            r_run   <= n_run;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            o_read_byte      <= n_read_byte;
            o_write_enable   <= n_wr_en;
            o_write_space    <= n_wr_space;
            o_write_address  <= n_wr_addr;
            o_write_data     <= n_wr_data;
            o_source_space   <= n_src_space;
            o_source_address <= n_src_addr;
            o_beats_left     <= n_run;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // A held item in the input register stays put until it executes
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !exec |=> r_in_valid && $stable(r_in_opcode) && $stable(r_in_reg))
        else $error("held item changed before it executed");

    // No write request leaves stray payload
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_enable |->
            o_write_space == SP_CPU && o_write_address == 16'h0000 &&
            o_write_data == 8'h00)
        else $error("payload on a result without a write request");

    // Sprite writes stay inside sprite memory
    a_sprite_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_enable && o_write_space == SP_SPRITE |->
            o_write_address < 16'(SPRITE_BYTES))
        else $error("sprite write beyond sprite memory");

    // Palette source is announced only in palette mode
    a_palette_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_source_space == SP_PALETTE |->
            r_ctrl[2:0] == MODE_PALETTE)
        else $error("palette source outside palette mode");

    // Run counter never exceeds a full run
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_run <= RUN_FULL)
        else $error("run counter above a full run");
`endif

endmodule
